// ----- hdl/tbo_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle/box overlap package
// Shared widths and constants for the separating axis test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package tbo_pkg;
  localparam int COORD_WIDTH = 16;
  localparam int VERTEX_WIDTH = 48;
endpackage
`default_nettype wire

// ----- hdl/tbo_stage1.sv -----
// ----------------------------------------------------------------------------
// Setup stage
// Builds centered doubled vertices, box extents and triangle edges.
// ----------------------------------------------------------------------------
`default_nettype none
module tbo_stage1 #(
  parameter int CW = tbo_pkg::COORD_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] lo [3],
  input  wire logic signed [CW-1:0] hi [3],
  input  wire logic signed [CW-1:0] v  [3][3],
  output logic signed [CW+2:0]      u  [3][3],
  output logic signed [CW:0]        ext [3],
  output logic signed [CW:0]        f  [3][3]
);
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ext[i] <= (CW+1)'(hi[i]) - (CW+1)'(lo[i]);
        f[0][i] <= (CW+1)'(v[1][i]) - (CW+1)'(v[0][i]);
        f[1][i] <= (CW+1)'(v[2][i]) - (CW+1)'(v[1][i]);
        f[2][i] <= (CW+1)'(v[0][i]) - (CW+1)'(v[2][i]);
        for (int k = 0; k < 3; k++) begin
          u[k][i] <= ((CW+3)'(v[k][i]) <<< 1) - (CW+3)'(lo[i]) - (CW+3)'(hi[i]);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/tbo_axes.sv -----
// ----------------------------------------------------------------------------
// Edge axis stage
// Projects the box and triangle on the twelve box and edge cross axes.
// ----------------------------------------------------------------------------
`default_nettype none
module tbo_axes #(
  parameter int CW = tbo_pkg::COORD_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic [1:0]           en,
  input  wire logic signed [CW+2:0] u   [3][3],
  input  wire logic signed [CW:0]   ext [3],
  input  wire logic signed [CW:0]   f   [3][3],
  output logic                      sep
);
  localparam int PW = 2*CW + 6;
  logic signed [PW-1:0] p [12][3];
  logic signed [PW-1:0] r [12];
  logic sep_ax [12];
  logic signed [PW-1:0] pr [12][3];
  logic signed [PW-1:0] rr [12];
  logic signed [PW-1:0] mn, mx;
  logic acc;

  function automatic logic signed [PW-1:0] ab(input logic signed [CW:0] x);
    logic signed [PW-1:0] e;
    e = PW'(x);
    return (e < 0) ? -e : e;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) p[i][k] = PW'(u[k][i]);
      r[i] = PW'(ext[i]);
    end
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        p[3+3*e][k] = PW'(u[k][2])*PW'(f[e][1]) - PW'(u[k][1])*PW'(f[e][2]);
        p[4+3*e][k] = PW'(u[k][0])*PW'(f[e][2]) - PW'(u[k][2])*PW'(f[e][0]);
        p[5+3*e][k] = PW'(u[k][1])*PW'(f[e][0]) - PW'(u[k][0])*PW'(f[e][1]);
      end
      r[3+3*e] = PW'(ext[1])*ab(f[e][2]) + PW'(ext[2])*ab(f[e][1]);
      r[4+3*e] = PW'(ext[0])*ab(f[e][2]) + PW'(ext[2])*ab(f[e][0]);
      r[5+3*e] = PW'(ext[0])*ab(f[e][1]) + PW'(ext[1])*ab(f[e][0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pr <= p;
      rr <= r;
    end
  end

  always_comb begin
    acc = 1'b0;
    mn = '0;
    mx = '0;
    for (int a = 0; a < 12; a++) begin
      mn = pr[a][0];
      mx = pr[a][0];
      for (int k = 1; k < 3; k++) begin
        if (pr[a][k] < mn) mn = pr[a][k];
        if (pr[a][k] > mx) mx = pr[a][k];
      end
      sep_ax[a] = (mn > rr[a]) || (mx < -rr[a]);
      acc = acc | sep_ax[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sep <= acc;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/tbo_plane.sv -----
// ----------------------------------------------------------------------------
// Plane stage
// Tests the triangle normal axis over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module tbo_plane #(
  parameter int CW = tbo_pkg::COORD_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic [2:0]           en,
  input  wire logic signed [CW+2:0] u   [3][3],
  input  wire logic signed [CW:0]   ext [3],
  input  wire logic signed [CW:0]   f   [3][3],
  output logic                      sep
);
  localparam int NW = 2*CW + 4;
  localparam int DW = 3*CW + 10;
  logic signed [NW-1:0] n [3];
  logic signed [NW-1:0] na [3];
  logic signed [CW+2:0] u0 [3];
  logic signed [CW:0]   ex [3];
  logic signed [DW-1:0] dp [3];
  logic signed [DW-1:0] rp [3];
  logic signed [DW-1:0] d, r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n[0] <= NW'(f[0][1])*NW'(f[1][2]) - NW'(f[0][2])*NW'(f[1][1]);
      n[1] <= NW'(f[0][2])*NW'(f[1][0]) - NW'(f[0][0])*NW'(f[1][2]);
      n[2] <= NW'(f[0][0])*NW'(f[1][1]) - NW'(f[0][1])*NW'(f[1][0]);
      for (int i = 0; i < 3; i++) begin
        u0[i] <= u[0][i];
        ex[i] <= ext[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) na[i] = (n[i] < 0) ? -n[i] : n[i];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        dp[i] <= DW'(n[i]) * DW'(u0[i]);
        rp[i] <= DW'(na[i]) * DW'(ex[i]);
      end
    end
  end

  assign d = dp[0] + dp[1] + dp[2];
  assign r = rp[0] + rp[1] + rp[2];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sep <= (d > r) || (-r > d);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/triangle_box_overlap_test_top.sv -----
// Four register stages lie between an accepted input transaction and a valid result.
// Throughput: one transaction per cycle; the four stage pipeline advances
// whenever its last stage is empty or its result is taken.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Triangle/box overlap test
// Separating axis test of an axis-aligned box against a triangle.
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_box_overlap_test_top #(
  parameter int COORD_WIDTH = tbo_pkg::COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] box_low_x,
  input  wire logic signed [COORD_WIDTH-1:0] box_low_y,
  input  wire logic signed [COORD_WIDTH-1:0] box_low_z,
  input  wire logic signed [COORD_WIDTH-1:0] box_high_x,
  input  wire logic signed [COORD_WIDTH-1:0] box_high_y,
  input  wire logic signed [COORD_WIDTH-1:0] box_high_z,
  input  wire logic [tbo_pkg::VERTEX_WIDTH-1:0] vertex_a,
  input  wire logic [tbo_pkg::VERTEX_WIDTH-1:0] vertex_b,
  input  wire logic [tbo_pkg::VERTEX_WIDTH-1:0] vertex_c,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               overlaps
);
  localparam int CW = COORD_WIDTH;
  logic signed [CW-1:0] lo [3];
  logic signed [CW-1:0] hi [3];
  logic signed [CW-1:0] v  [3][3];
  logic signed [CW+2:0] u  [3][3];
  logic signed [CW:0]   ext [3];
  logic signed [CW:0]   f  [3][3];
  logic sep_ax, sep_pl;
  logic [3:0] vld;
  logic [3:0] en;
  logic [tbo_pkg::VERTEX_WIDTH-1:0] vin [3];

  assign lo[0] = box_low_x;
  assign lo[1] = box_low_y;
  assign lo[2] = box_low_z;
  assign hi[0] = box_high_x;
  assign hi[1] = box_high_y;
  assign hi[2] = box_high_z;
  assign vin[0] = vertex_a;
  assign vin[1] = vertex_b;
  assign vin[2] = vertex_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) v[k][i] = vin[k][CW*i +: CW];
    end
  end

  // Stage i loads when its own register is empty or drains downstream.
  always_comb begin
    en[3] = !vld[3] || out_ready;
    for (int s = 2; s >= 0; s--) en[s] = !vld[s] || en[s+1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int s = 1; s < 4; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  tbo_stage1 #(.CW(CW)) u_setup (
    .clk(clk), .en(en[0]), .lo(lo), .hi(hi), .v(v), .u(u), .ext(ext), .f(f)
  );

  tbo_axes #(.CW(CW)) u_axes (
    .clk(clk), .en(en[2:1]), .u(u), .ext(ext), .f(f), .sep(sep_ax)
  );

  tbo_plane #(.CW(CW)) u_plane (
    .clk(clk), .en(en[3:1]), .u(u), .ext(ext), .f(f), .sep(sep_pl)
  );

  // The edge axis result lands one stage early; it is held in step here.
  logic sep_ax_d;
  always_ff @(posedge clk) begin
    if (en[3]) sep_ax_d <= sep_ax;
  end

  assign out_valid = vld[3];
  assign overlaps = !(sep_ax_d || sep_pl);
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Triangle/box overlap testbench
// Drives box and triangle transactions through the overlap pipeline with
// random idling and stalls, predicts each verdict with an exact separating
// axis model, and checks every result in order against that prediction.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int COORD_WIDTH = tbo_pkg::COORD_WIDTH;
  localparam int VERTEX_WIDTH = tbo_pkg::VERTEX_WIDTH;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [COORD_WIDTH-1:0] lo [3];
    logic signed [COORD_WIDTH-1:0] hi [3];
    logic [VERTEX_WIDTH-1:0] v [3];
  } tri_box_t;

  class verdict_board;
    bit pending_q [$];
    int errors;

    function void note_input(bit verdict);
      pending_q.insert(pending_q.size(), verdict);
    endfunction

    function void check_result(bit got);
      bit want;
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction, overlaps=%0d", got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (want !== got) begin
          $error("field overlaps: expected %0d actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_WIDTH-1:0] box_low_x = '0, box_low_y = '0, box_low_z = '0;
  logic signed [COORD_WIDTH-1:0] box_high_x = '0, box_high_y = '0, box_high_z = '0;
  logic [VERTEX_WIDTH-1:0] vertex_a = '0, vertex_b = '0, vertex_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic overlaps;

  verdict_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  triangle_box_overlap_test_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .box_low_x(box_low_x), .box_low_y(box_low_y), .box_low_z(box_low_z),
    .box_high_x(box_high_x), .box_high_y(box_high_y), .box_high_z(box_high_z),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
    .out_valid(out_valid), .out_ready(out_ready), .overlaps(overlaps)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint mag(longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic bit axis_separates(vec3_t ax, vec3_t u0, vec3_t u1, vec3_t u2,
                                        vec3_t ext);
    longint p [3];
    longint r, lo, hi;
    p[0] = ax[0] * u0[0] + ax[1] * u0[1] + ax[2] * u0[2];
    p[1] = ax[0] * u1[0] + ax[1] * u1[1] + ax[2] * u1[2];
    p[2] = ax[0] * u2[0] + ax[1] * u2[1] + ax[2] * u2[2];
    r = ext[0] * mag(ax[0]) + ext[1] * mag(ax[1]) + ext[2] * mag(ax[2]);
    lo = p[0];
    hi = p[0];
    for (int k = 1; k < 3; k++) begin
      if (p[k] < lo) lo = p[k];
      if (p[k] > hi) hi = p[k];
    end
    return (lo > r) || (hi < -r);
  endfunction

  function automatic bit predict_overlap(tri_box_t t);
    vec3_t ext, u0, u1, u2, ax;
    longint vx [3][3];
    longint f [3][3];
    longint n [3];
    logic signed [127:0] d, r, wa, wb;
    for (int i = 0; i < 3; i++) begin
      ext[i] = longint'(t.hi[i]) - longint'(t.lo[i]);
      for (int k = 0; k < 3; k++)
        vx[k][i] = longint'($signed(t.v[k][i*COORD_WIDTH +: COORD_WIDTH]));
      u0[i] = 2 * vx[0][i] - (longint'(t.lo[i]) + longint'(t.hi[i]));
      u1[i] = 2 * vx[1][i] - (longint'(t.lo[i]) + longint'(t.hi[i]));
      u2[i] = 2 * vx[2][i] - (longint'(t.lo[i]) + longint'(t.hi[i]));
    end
    for (int i = 0; i < 3; i++) begin
      f[0][i] = vx[1][i] - vx[0][i];
      f[1][i] = vx[2][i] - vx[1][i];
      f[2][i] = vx[0][i] - vx[2][i];
    end
    for (int i = 0; i < 3; i++) begin
      ax = '{0, 0, 0};
      ax[i] = 1;
      if (axis_separates(ax, u0, u1, u2, ext)) return 1'b0;
    end
    for (int k = 0; k < 3; k++) begin
      ax = '{0, -f[k][2], f[k][1]};
      if (axis_separates(ax, u0, u1, u2, ext)) return 1'b0;
      ax = '{f[k][2], 0, -f[k][0]};
      if (axis_separates(ax, u0, u1, u2, ext)) return 1'b0;
      ax = '{-f[k][1], f[k][0], 0};
      if (axis_separates(ax, u0, u1, u2, ext)) return 1'b0;
    end
    n[0] = f[0][1] * f[1][2] - f[0][2] * f[1][1];
    n[1] = f[0][2] * f[1][0] - f[0][0] * f[1][2];
    n[2] = f[0][0] * f[1][1] - f[0][1] * f[1][0];
    d = '0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      wa = n[i];
      wb = u0[i];
      d = d + wa * wb;
      wa = ext[i];
      wb = mag(n[i]);
      r = r + wa * wb;
    end
    return !((d > r) || (-r > d));
  endfunction

  always @(posedge clk) begin
    tri_box_t seen;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.lo = '{box_low_x, box_low_y, box_low_z};
        seen.hi = '{box_high_x, box_high_y, box_high_z};
        seen.v = '{vertex_a, vertex_b, vertex_c};
        board.note_input(predict_overlap(seen));
      end
      if (out_valid && out_ready) board.check_result(overlaps);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [VERTEX_WIDTH-1:0] pack_vertex(int x, int y, int z);
    logic [COORD_WIDTH-1:0] px, py, pz;
    px = COORD_WIDTH'(x);
    py = COORD_WIDTH'(y);
    pz = COORD_WIDTH'(z);
    return {pz, py, px};
  endfunction

  function automatic int clamp16(int a);
    if (a > 32767) return 32767;
    if (a < -32768) return -32768;
    return a;
  endfunction

  function automatic tri_box_t make_box(int lx, int ly, int lz, int hx, int hy, int hz,
                                        logic [VERTEX_WIDTH-1:0] a,
                                        logic [VERTEX_WIDTH-1:0] b,
                                        logic [VERTEX_WIDTH-1:0] c);
    tri_box_t t;
    t.lo = '{COORD_WIDTH'(lx), COORD_WIDTH'(ly), COORD_WIDTH'(lz)};
    t.hi = '{COORD_WIDTH'(hx), COORD_WIDTH'(hy), COORD_WIDTH'(hz)};
    t.v = '{a, b, c};
    return t;
  endfunction

  function automatic tri_box_t random_case();
    tri_box_t t;
    int mode, span, c, h, lo, hi;
    int pick;
    mode = $urandom_range(99);
    if (mode < 15) begin
      for (int i = 0; i < 3; i++) begin
        t.lo[i] = COORD_WIDTH'($urandom_range(65535));
        t.hi[i] = COORD_WIDTH'($urandom_range(65535));
        t.v[i] = VERTEX_WIDTH'({$urandom(), $urandom()});
      end
      return t;
    end
    pick = $urandom_range(2);
    span = (pick == 0) ? 16 : (pick == 1) ? 1000 : 16000;
    for (int i = 0; i < 3; i++) begin
      c = $signed($urandom_range(65535)) - 32768;
      h = $urandom_range(span);
      lo = clamp16(c - h);
      hi = clamp16(c + h);
      if (mode < 25) begin
        t.lo[i] = COORD_WIDTH'(hi);
        t.hi[i] = COORD_WIDTH'(lo);
      end else begin
        t.lo[i] = COORD_WIDTH'(lo);
        t.hi[i] = COORD_WIDTH'(hi);
      end
    end
    for (int k = 0; k < 3; k++) begin
      int p [3];
      for (int i = 0; i < 3; i++) begin
        c = (int'(t.lo[i]) + int'(t.hi[i])) / 2;
        p[i] = clamp16(c + int'($urandom_range(6 * span + 2)) - 3 * span - 1);
      end
      t.v[k] = pack_vertex(p[0], p[1], p[2]);
    end
    return t;
  endfunction

  task automatic send_case(tri_box_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    box_low_x <= t.lo[0];
    box_low_y <= t.lo[1];
    box_low_z <= t.lo[2];
    box_high_x <= t.hi[0];
    box_high_y <= t.hi[1];
    box_high_z <= t.hi[2];
    vertex_a <= t.v[0];
    vertex_b <= t.v[1];
    vertex_c <= t.v[2];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending_q.size() != 0) @(negedge clk);
  endtask

  localparam int MAXC = 32767;
  localparam int MINC = -32768;

  initial begin
    tri_box_t dir [$];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    dir.insert(dir.size(), make_box(MINC, MINC, MINC, MAXC, MAXC, MAXC,
                           pack_vertex(MINC, MINC, MINC),
                           pack_vertex(MAXC, MAXC, MAXC), pack_vertex(MAXC, MINC, MAXC)));
    dir.insert(dir.size(), make_box(0, 0, 0, 10, 10, 10, pack_vertex(10, 10, 10),
                           pack_vertex(10, 10, 10), pack_vertex(10, 10, 10)));
    dir.insert(dir.size(), make_box(0, 0, 0, 10, 10, 10, pack_vertex(11, 10, 10),
                           pack_vertex(11, 10, 10), pack_vertex(11, 10, 10)));
    dir.insert(dir.size(), make_box(0, 0, 0, 10, 10, 10, pack_vertex(10, -5, -5),
                           pack_vertex(10, 20, -5), pack_vertex(10, -5, 20)));
    dir.insert(dir.size(), make_box(0, 0, 0, 10, 10, 10, pack_vertex(-5, -5, 30),
                           pack_vertex(30, -5, -5), pack_vertex(-5, 30, -5)));
    dir.insert(dir.size(), make_box(0, 0, 0, 10, 10, 10, pack_vertex(-20, -20, 40),
                           pack_vertex(40, -20, -20), pack_vertex(-20, 40, -20)));
    dir.insert(dir.size(), make_box(0, 0, 0, 10, 10, 10, pack_vertex(12, -1, 5),
                           pack_vertex(-1, 12, 5), pack_vertex(-1, 12, 6)));
    dir.insert(dir.size(), make_box(10, 10, 10, 0, 0, 0, pack_vertex(5, 5, 5),
                           pack_vertex(6, 5, 5), pack_vertex(5, 6, 5)));
    dir.insert(dir.size(), make_box(5, 5, 5, 5, 5, 5, pack_vertex(0, 0, 5),
                           pack_vertex(10, 0, 5), pack_vertex(0, 10, 5)));
    dir.insert(dir.size(), make_box(5, 5, 5, 5, 5, 5, pack_vertex(0, 0, 6),
                           pack_vertex(10, 0, 6), pack_vertex(0, 10, 6)));
    dir.insert(dir.size(), make_box(0, 0, 0, 4, 4, 4, pack_vertex(-3, 2, 2),
                           pack_vertex(9, 2, 2), pack_vertex(3, 2, 2)));
    dir.insert(dir.size(), make_box(MINC, MINC, MINC, MINC, MINC, MINC, '0, '0, '0));
    dir.insert(dir.size(), make_box(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, '1, '1, '1));
    dir.insert(dir.size(), make_box(-1, -1, -1, 0, 0, 0, '1, '0, '1));
    dir.insert(dir.size(), make_box(MAXC, MAXC, MAXC, MINC, MINC, MINC,
                           pack_vertex(0, 0, 0),
                           pack_vertex(1, 0, 0), pack_vertex(0, 1, 0)));
    dir.insert(dir.size(), make_box(MINC, MINC, MINC, MAXC, MAXC, MAXC,
                           pack_vertex(MAXC, MINC, 0),
                           pack_vertex(MINC, MAXC, 0), pack_vertex(MAXC, MAXC, MINC)));
    dir.insert(dir.size(), make_box(100, 100, 100, 200, 200, 200,
                           pack_vertex(MINC, MINC, MINC),
                           pack_vertex(MAXC, MAXC, MINC), pack_vertex(MAXC, MAXC, MAXC)));
    dir.insert(dir.size(), make_box(0, 0, 0, 1, 1, 1, pack_vertex(MAXC, MAXC, MAXC),
                           pack_vertex(MINC, MAXC, MINC), pack_vertex(MAXC, MINC, MINC)));
    foreach (dir[i]) send_case(dir[i]);

    hold_cycles = 300;
    repeat (40) send_case(random_case());
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 72 : (phase == 3) ? 28 : 0;
      stall_pct = (phase == 2) ? 72 : (phase == 3) ? 28 : 0;
      repeat (480) send_case(random_case());
      if (phase == 1) drain();
    end
    idle_pct = 0;
    stall_pct = 0;
    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
